FILE: rtl/rgbahn_pkg.sv
// ----------------------------------------------------------------------------
// rgbahn_pkg
// Shared sizes and opcodes of the normalized RGBA histogram.
// ----------------------------------------------------------------------------
`default_nettype none
package rgbahn_pkg;
  localparam int BIN_COUNT     = 256;
  localparam int COUNT_BITS    = 24;
  localparam int FRACTION_BITS = 16;
  localparam int CHANNELS      = 4;
  localparam int CH_BITS       = 2;
  localparam int BIN_BITS      = $clog2(BIN_COUNT);
  localparam int LEVEL_BITS    = FRACTION_BITS + 1;
  localparam int ROW_BITS      = CHANNELS * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;
endpackage
`default_nettype wire

FILE: rtl/rgbahn_ram.sv
// ----------------------------------------------------------------------------
// rgbahn_ram
// Bin memory, one row per bin holding all four channel counts. Per-row valid
// bits make a cleared row read as zero.
// ----------------------------------------------------------------------------
`default_nettype none
module rgbahn_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     clr,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rq;
  logic             vq;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rq <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
      vq    <= 1'b0;
    end else begin
      vq <= valid[raddr];
      if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = vq ? rq : '0;
endmodule
`default_nettype wire

FILE: rtl/rgbahn_div.sv
// ----------------------------------------------------------------------------
// rgbahn_div
// Restoring divider, one quotient bit per cycle: count * 2^F / peak, with
// count never above peak.
// ----------------------------------------------------------------------------
`default_nettype none
module rgbahn_div
  import rgbahn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [COUNT_BITS-1:0] count,
  input  wire logic [COUNT_BITS-1:0] peak,
  output logic                       done,
  output logic      [LEVEL_BITS-1:0] quot
);
  localparam int N_BITS = $clog2(LEVEL_BITS + 1);

  logic [COUNT_BITS:0]   rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [N_BITS-1:0]     n;
  logic                  busy;
  logic                  ge;
  logic [COUNT_BITS:0]   diff;

  assign ge   = rem >= {1'b0, dvs};
  assign diff = ge ? (rem - {1'b0, dvs}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && n == N_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, count};
      dvs  <= peak;
      n    <= N_BITS'(LEVEL_BITS);
      quot <= '0;
    end else if (busy) begin
      // remainder stays below divisor, so the shift cannot overflow
      rem  <= {diff[COUNT_BITS-1:0], 1'b0};
      quot <= {quot[LEVEL_BITS-2:0], ge};
      n    <= n - N_BITS'(1);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rgba_histogram_normalized_top.sv
// ----------------------------------------------------------------------------
// rgba_histogram_normalized_top
// Four-channel pixel histogram with normalized bin read-out.
// ----------------------------------------------------------------------------
// Accumulate: read-modify-write of the bin row, one per channel.
// Clear: applied on acceptance. Read: row captured, then the shared
// bit-serial divider runs once per channel; result held until taken.
// Reset (synchronous) empties all bins through the row valid bits and zeroes
// the peaks at once; no clearing pass.
`default_nettype none
module rgba_histogram_normalized_top
  import rgbahn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            opcode,
  input  wire logic [7:0]            red,
  input  wire logic [7:0]            green,
  input  wire logic [7:0]            blue,
  input  wire logic [7:0]            alpha,
  input  wire logic [7:0]            bin_index,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [LEVEL_BITS-1:0] red_level,
  output logic      [LEVEL_BITS-1:0] green_level,
  output logic      [LEVEL_BITS-1:0] blue_level,
  output logic      [LEVEL_BITS-1:0] alpha_level,
  output logic      [COUNT_BITS-1:0] red_tally,
  output logic      [COUNT_BITS-1:0] green_tally,
  output logic      [COUNT_BITS-1:0] blue_tally,
  output logic      [COUNT_BITS-1:0] alpha_tally,
  output logic                       empty_flag
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ARD    = 7'b0000010,
    S_AWR    = 7'b0000100,
    S_RCAP   = 7'b0001000,
    S_DSTART = 7'b0010000,
    S_DWAIT  = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t                state, state_next;
  logic [CH_BITS-1:0]    ch;
  logic [7:0]            px [CHANNELS];
  logic [7:0]            bin;
  logic [COUNT_BITS-1:0] peak  [CHANNELS];
  logic [COUNT_BITS-1:0] tally [CHANNELS];
  logic [LEVEL_BITS-1:0] level [CHANNELS];

  logic                  accept;
  op_t                   op;
  logic [BIN_BITS-1:0]   raddr;
  logic [ROW_BITS-1:0]   row;
  logic [ROW_BITS-1:0]   wrow;
  logic [COUNT_BITS-1:0] lane, inc;
  logic                  we, clr, px_ok, bin_ok;
  logic                  div_start, div_done;
  logic [LEVEL_BITS-1:0] quot;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(opcode);
  assign px_ok    = 32'(px[ch]) < BIN_COUNT;
  assign bin_ok   = 32'(bin) < BIN_COUNT;
  assign clr      = accept && op == OP_CLEAR;
  assign we       = (state == S_AWR);
  assign div_start = (state == S_DSTART);

  always_comb begin
    raddr = BIN_BITS'(bin_index);
    if (state == S_ARD) begin
      raddr = BIN_BITS'(px[ch]);
    end
  end

  always_comb begin
    lane = row[ch*COUNT_BITS +: COUNT_BITS];
    inc  = (lane == COUNT_MAX) ? lane : lane + COUNT_BITS'(1);
    wrow = row;
    wrow[ch*COUNT_BITS +: COUNT_BITS] = inc;
  end

  rgbahn_ram #(
    .DEPTH (BIN_COUNT),
    .WIDTH (ROW_BITS)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .clr   (clr),
    .we    (we),
    .waddr (BIN_BITS'(px[ch])),
    .wdata (wrow),
    .raddr (raddr),
    .rdata (row)
  );

  rgbahn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .count (tally[ch]),
    .peak  (peak[ch]),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (op == OP_ACCUM) begin
            state_next = S_ARD;
          end else if (op == OP_READ) begin
            state_next = S_RCAP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_ARD: begin
        if (px_ok) begin
          state_next = S_AWR;
        end else if (ch == CH_BITS'(CHANNELS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_AWR: begin
        state_next = (ch == CH_BITS'(CHANNELS - 1)) ? S_IDLE : S_ARD;
      end
      S_RCAP:   state_next = S_DSTART;
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          state_next = (ch == CH_BITS'(CHANNELS - 1)) ? S_FIN : S_DSTART;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < CHANNELS; j++) begin
        peak[j] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (clr) begin
        for (int j = 0; j < CHANNELS; j++) begin
          peak[j] <= '0;
        end
      end
      if (accept) begin
        ch <= '0;
      end
      if (state == S_ARD && !px_ok) begin
        ch <= ch + CH_BITS'(1);
      end
      if (state == S_AWR) begin
        ch <= ch + CH_BITS'(1);
        if (inc > peak[ch]) begin
          peak[ch] <= inc;
        end
      end
      if (state == S_DWAIT && div_done) begin
        ch <= ch + CH_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px[0] <= red;
      px[1] <= green;
      px[2] <= blue;
      px[3] <= alpha;
      bin   <= bin_index;
    end
    if (state == S_RCAP) begin
      for (int j = 0; j < CHANNELS; j++) begin
        tally[j] <= bin_ok ? row[j*COUNT_BITS +: COUNT_BITS] : '0;
      end
    end
    if (state == S_DWAIT && div_done) begin
      // zero peak gives level 0 instead of a meaningless quotient
      level[ch] <= (peak[ch] == '0) ? '0 : quot;
    end
    if (state == S_FIN && (!out_valid || out_ready)) begin
      red_level   <= level[0];
      green_level <= level[1];
      blue_level  <= level[2];
      alpha_level <= level[3];
      red_tally   <= tally[0];
      green_tally <= tally[1];
      blue_tally  <= tally[2];
      alpha_tally <= tally[3];
      empty_flag  <= (peak[0] == '0) || (peak[1] == '0) ||
                     (peak[2] == '0) || (peak[3] == '0);
    end
  end
endmodule
`default_nettype wire

FILE: sim/rgba_histogram_normalized_top_tb.sv
// ----------------------------------------------------------------------------
// rgba_histogram_normalized_top_tb
// Self-checking bench: random pixels, bin reads and clears are driven through
// the valid/ready input; every read result is compared with a local
// histogram model kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module rgba_histogram_normalized_top_tb;
  import rgbahn_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 830;

  typedef struct packed {
    op_t        op;
    logic [7:0] r, g, b, a, idx;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] lvl0, lvl1, lvl2, lvl3;
    logic [COUNT_BITS-1:0] cnt0, cnt1, cnt2, cnt3;
    logic                  empty;
  } readout_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] opcode = '0;
  logic [7:0] red = '0, green = '0, blue = '0, alpha = '0, bin_index = '0;
  logic out_valid, out_ready = 1'b0;
  logic [LEVEL_BITS-1:0] red_level, green_level, blue_level, alpha_level;
  logic [COUNT_BITS-1:0] red_tally, green_tally, blue_tally, alpha_tally;
  logic empty_flag;

  rgba_histogram_normalized_top u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cmd_t     pending_cmds[$];
  readout_t expected_reads[$];
  logic [COUNT_BITS-1:0] hist[CHANNELS][BIN_COUNT];
  logic [COUNT_BITS-1:0] peak[CHANNELS];
  int errors = 0, n_sent = 0, n_reads = 0, n_pixels = 0, idle_cycles = 0;
  bit stim_done = 0, quiet = 0, sat_mode = 0;

  function automatic logic [LEVEL_BITS-1:0] level_of(logic [COUNT_BITS-1:0] c,
                                                     logic [COUNT_BITS-1:0] p);
    logic [63:0] q;
    if (p == 0) return '0;
    q = ({40'd0, c} << FRACTION_BITS) / {40'd0, p};
    return q[LEVEL_BITS-1:0];
  endfunction

  // applies one accepted item to the histogram model
  task automatic apply_cmd(cmd_t c);
    logic [7:0] v[CHANNELS];
    logic [COUNT_BITS-1:0] t[CHANNELS];
    logic [LEVEL_BITS-1:0] l[CHANNELS];
    readout_t rd;
    v = '{c.r, c.g, c.b, c.a};
    case (c.op)
      OP_ACCUM: begin
        n_pixels++;
        for (int k = 0; k < CHANNELS; k++) begin
          if (hist[k][v[k]] != COUNT_MAX) hist[k][v[k]]++;
          if (hist[k][v[k]] > peak[k]) peak[k] = hist[k][v[k]];
        end
      end
      OP_CLEAR: begin
        for (int k = 0; k < CHANNELS; k++) begin
          peak[k] = '0;
          for (int i = 0; i < BIN_COUNT; i++) hist[k][i] = '0;
        end
      end
      OP_READ: begin
        rd.empty = 1'b0;
        for (int k = 0; k < CHANNELS; k++) begin
          t[k] = hist[k][c.idx];
          l[k] = level_of(t[k], peak[k]);
          if (peak[k] == 0) rd.empty = 1'b1;
        end
        rd.lvl0 = l[0]; rd.lvl1 = l[1]; rd.lvl2 = l[2]; rd.lvl3 = l[3];
        rd.cnt0 = t[0]; rd.cnt1 = t[1]; rd.cnt2 = t[2]; rd.cnt3 = t[3];
        expected_reads = {expected_reads, rd};
      end
      default: ;
    endcase
  endtask

  function automatic cmd_t mk(op_t op, int r, int g, int b, int a, int idx);
    cmd_t c;
    c.op = op; c.r = 8'(r); c.g = 8'(g); c.b = 8'(b); c.a = 8'(a);
    c.idx = 8'(idx);
    return c;
  endfunction

  task automatic queue_cmd(cmd_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  // set at the rising edge when the input item is taken
  bit in_acc = 0;

  // driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_acc) begin
        apply_cmd(pending_cmds.pop_front());
        n_sent++;
      end
      if (!in_valid || in_acc) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(1, 12);
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_valid  <= 1'b1;
          opcode    <= pending_cmds[0].op;
          red       <= pending_cmds[0].r;
          green     <= pending_cmds[0].g;
          blue      <= pending_cmds[0].b;
          alpha     <= pending_cmds[0].a;
          bin_index <= pending_cmds[0].idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  int out_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    readout_t e;
    in_acc = !rst && in_valid && in_ready;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        n_reads++;
        if (expected_reads.size() == 0) begin
          $error("read result with no read pending");
          errors++;
        end else begin
          e = expected_reads.pop_front();
          check_field("red_level", e.lvl0, red_level);
          check_field("green_level", e.lvl1, green_level);
          check_field("blue_level", e.lvl2, blue_level);
          check_field("alpha_level", e.lvl3, alpha_level);
          check_field("red_tally", e.cnt0, red_tally);
          check_field("green_tally", e.cnt1, green_tally);
          check_field("blue_tally", e.cnt2, blue_tally);
          check_field("alpha_tally", e.cnt3, alpha_tally);
          check_field("empty_flag", e.empty, empty_flag);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [7:0] pick_value(bit hot);
    // hot pixels crowd a few bins so levels reach 1.0 and fractions vary
    if (hot) return 8'($urandom_range(0, 3) * 85);
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int r;
    cmd_t c;
    for (int k = 0; k < CHANNELS; k++) begin
      peak[k] = '0;
      for (int i = 0; i < BIN_COUNT; i++) hist[k][i] = '0;
    end
    // directed: empty reads, extremes, ignored opcode, clear
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 0));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 255));
    queue_cmd(mk(OP_ACCUM, 0, 255, 0, 255, 0));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 0));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 255));
    queue_cmd(mk(OP_ACCUM, 255, 255, 170, 85, 0));
    queue_cmd(mk(OP_ACCUM, 255, 0, 170, 85, 0));
    queue_cmd(mk(OP_ACCUM, 255, 1, 85, 85, 0));
    queue_cmd(mk(OP_NONE, 255, 255, 255, 255, 255));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 255));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 0));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 85));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 170));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 1));
    queue_cmd(mk(OP_CLEAR, 0, 0, 0, 0, 0));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 255));
    queue_cmd(mk(OP_ACCUM, 7, 7, 7, 7, 0));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 7));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0, 8));
    // random: mostly pixels, reads often enough for about two hundred results
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      c.op  = r < 72 ? OP_ACCUM : r < 96 ? OP_READ : r < 98 ? OP_CLEAR : OP_NONE;
      sat_mode = ($urandom_range(0, 1) == 1);
      c.r = pick_value(sat_mode); c.g = pick_value(sat_mode);
      c.b = pick_value(sat_mode); c.a = pick_value(sat_mode);
      c.idx = (c.op == OP_READ && $urandom_range(0, 1)) ? pick_value(1'b1)
                                                         : 8'($urandom_range(0, 255));
      queue_cmd(c);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (pending_cmds.size() < 150);
    quiet = 1;
    wait (pending_cmds.size() == 0 && !(in_valid && !in_ready));
    @(posedge clk);
    wait (expected_reads.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d items: %0d pixels counted, %0d bin reads checked",
             n_sent, n_pixels, n_reads);
    if (errors == 0 && expected_reads.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
rtl/rgbahn_pkg.sv
rtl/rgbahn_ram.sv
rtl/rgbahn_div.sv
rtl/rgba_histogram_normalized_top.sv
sim/rgba_histogram_normalized_top_tb.sv
